FILE: src/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

	// Field widths.
	localparam int VALUE_W = 63;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	// Digit storage sizing.
	localparam int MAX_DIGITS = 64;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

	// Two banks of digits, one being filled while the other drains.
	localparam int RAM_DEPTH = 2 * MAX_DIGITS;
	localparam int RAM_AW    = IDX_W + 1;

	// Long division: the working word is the value padded to a whole number of chunks.
	localparam int DIV_STEP = 8;
	localparam int WORK_W   = ((VALUE_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
	localparam int PHASES   = WORK_W / DIV_STEP;
	localparam int PHASE_W  = $clog2(PHASES);

	// Radix limits and reset value.
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// ASCII anchors.
	localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h41);

	// One finished conversion waiting to be emitted.
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] cnt;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// Digit memory write request.
	typedef struct packed {
		logic               en;
		logic [RAM_AW-1:0]  addr;
		logic [DIGIT_W-1:0] data;
	} ram_wr_t;

	// Digit memory read request.
	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
	} ram_rd_t;

	// Map a digit to its ASCII character.
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_W'(10)) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
		end
		return c;
	endfunction

endpackage

FILE: src/radix_digit_converter_core.sv
`timescale 1ns / 1ps

// Converts a 63-bit unsigned value to ASCII digits in the base held in the radix
// register (2 to 16; 0 and 1 act as 2, 17 and up act as 16), most significant digit
// first, one digit per strobe, with last set on the final digit; zero gives "0".
// Results leave on strobe for exactly one cycle and cannot be held off. The divider
// works 8 quotient bits per cycle, and a request keeps the front busy until all of its
// digits are divided (up to 63 for radix 2, 19 for radix 10, 16 for radix 16). The
// digits then stream out at one per cycle. When no earlier digits are still leaving,
// the finished conversion passes through the job queue and the back's idle state into
// a registered memory read that raises the first strobe. Otherwise it waits until the
// earlier run has left and the back is idle again, while the next request is divided.
// Up to two finished conversions can wait for output; busy stays high while a
// conversion is running or both are waiting. Write the radix only while idle.
module radix_digit_converter_core import rdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RADIX_W-1:0] cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base;
	qstat_t             qstat;
	ram_wr_t            wr;
	ram_rd_t            rd;
	logic               push;
	logic               pop;
	job_t               push_job;
	job_t               head;
	logic [DIGIT_W-1:0] rdata;

	// Radix register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Clamp the register into the supported range.
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	rdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.base     (base),
		.qstat    (qstat),
		.busy     (busy),
		.wr       (wr),
		.push     (push),
		.push_job (push_job)
	);

	rdc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rdata)
	);

	rdc_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	rdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.rd         (rd),
		.rdata      (rdata),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	// A finished conversion never arrives at a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("conversion pushed into a full queue");

	// The back never releases a conversion that is not queued.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("queue popped while empty");

	// A new request is never taken while both banks are claimed.
	a_accept_bank_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !qstat.full)
		else $error("request accepted with both digit banks in use");

	// No digit is emitted directly after the final digit of a run.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("digit emitted directly after the final digit of a run");

endmodule

FILE: src/rdc_ram.sv
`timescale 1ns / 1ps

module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/rdc_front.sv
`timescale 1ns / 1ps

module rdc_front import rdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	input  logic [RADIX_W-1:0] base,
	input  qstat_t             qstat,
	output logic               busy,
	output ram_wr_t            wr,
	output logic               push,
	output job_t               push_job
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_DIV  = 2'b10
	} front_state_t;

	front_state_t        state_q;
	logic [WORK_W-1:0]   work_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  base_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                bank_q;

	logic                accept;
	logic                digit_done;
	logic                conv_done;
	logic [DIGIT_W-1:0]  rem_nxt;
	logic [DIV_STEP-1:0] qbits;
	logic [WORK_W-1:0]   work_nxt;
	logic [RADIX_W-1:0]  trial;
	logic [CNT_W-1:0]    cnt_inc;

	assign accept = start && !busy;
	assign busy   = (state_q != F_IDLE) || qstat.full;

	// Restoring division of one chunk of the working word, most significant bit first.
	always_comb begin
		rem_nxt = rem_q;
		qbits   = '0;
		trial   = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {rem_nxt, work_q[WORK_W-1-i]};
			if (trial >= base_q) begin
				trial                 = trial - base_q;
				qbits[DIV_STEP-1-i]   = 1'b1;
			end
			rem_nxt = trial[DIGIT_W-1:0];
		end
		work_nxt = {work_q[WORK_W-DIV_STEP-1:0], qbits};
	end

	// A digit is final after the last chunk; the run ends on a zero quotient or a full store.
	assign digit_done = (state_q == F_DIV) && (phase_q == PHASE_W'(PHASES - 1));
	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign conv_done  = digit_done && ((work_nxt == '0) || (cnt_inc == CNT_W'(MAX_DIGITS)));

	assign wr.en   = digit_done;
	assign wr.addr = {bank_q, cnt_q[IDX_W-1:0]};
	assign wr.data = rem_nxt;

	assign push          = conv_done;
	assign push_job.bank = bank_q;
	assign push_job.cnt  = cnt_inc;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_DIV;
						phase_q <= '0;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					phase_q <= phase_q + PHASE_W'(1);
					if (digit_done) begin
						cnt_q <= cnt_inc;
					end
					if (conv_done) begin
						state_q <= F_IDLE;
						bank_q  <= !bank_q;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			work_q <= WORK_W'(value);
			rem_q  <= '0;
			base_q <= base;
		end else if (state_q == F_DIV) begin
			work_q <= work_nxt;
			rem_q  <= digit_done ? '0 : rem_nxt;
		end
	end

endmodule

FILE: src/rdc_jobq.sv
`timescale 1ns / 1ps

module rdc_jobq import rdc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	input  logic   pop,
	output job_t   head,
	output qstat_t qstat
);

	job_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign head        = ent_q[rptr_q];
	assign qstat.empty = (count_q == 2'd0);
	assign qstat.full  = (count_q == 2'd2);

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_job;
		end
	end

endmodule

FILE: src/rdc_back.sv
`timescale 1ns / 1ps

module rdc_back import rdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  qstat_t             qstat,
	input  job_t               head,
	output logic               pop,
	output ram_rd_t            rd,
	input  logic [DIGIT_W-1:0] rdata,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} back_state_t;

	back_state_t      state_q;
	logic             bank_q;
	logic [IDX_W-1:0] idx_q;
	logic             valid_s1;
	logic             last_s1;

	logic             at_end;

	assign at_end = (idx_q == '0);

	// Read the stored digits from the top index down.
	assign rd.en   = (state_q == B_RUN);
	assign rd.addr = {bank_q, idx_q};
	assign pop     = (state_q == B_RUN) && at_end;

	// Memory data arrives in the cycle after the read, together with its marks.
	assign strobe     = valid_s1;
	assign last       = last_s1;
	assign digit_char = glyph(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= (state_q == B_RUN);
			last_s1  <= (state_q == B_RUN) && at_end;
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (at_end) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Index and bank of the run being emitted.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			bank_q <= head.bank;
			idx_q  <= IDX_W'(head.cnt - CNT_W'(1));
		end else if (state_q == B_RUN) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

endmodule
